// ===== design/ps2m_pkg.sv =====
// shared types, codes and reset constants for the ps/2 mouse cursor tracker
`default_nettype none

package ps2m_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int WHEEL_BITS_DEF = 16;

  localparam int CFG_DATA_W = 13;
  localparam int REG_IDX_W = 2;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd768;

  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WHEEL_MODE    = 2'd2;

  localparam logic [1:0] FUNC_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_INJECT = 2'd1;
  localparam logic [1:0] FUNC_POLL   = 2'd2;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_APPLIED = 3'd1;
  localparam logic [2:0] ST_OVF     = 3'd2;
  localparam logic [2:0] ST_RESYNC  = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_OTHER   = 3'd5;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         data_byte;
    logic               from_mouse;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [7:0]         button_bits;
    logic signed [7:0]  wheel_delta;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        cursor_x;
    logic [11:0]        cursor_y;
    logic [2:0]         buttons;
    logic               event_seen;
    logic signed [15:0] wheel_total;
    logic [2:0]         item_status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/ps2m_cfg.sv =====
// configuration registers and derived cursor bounds
`default_nettype none

module ps2m_cfg import ps2m_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic      [COORD_BITS-1:0] bound_x,
  output logic      [COORD_BITS-1:0] bound_y,
  output logic                       wheel_mode
);

  localparam int BW = CFG_DATA_W + 4;
  localparam logic [BW-1:0] CMAX = BW'((1 << COORD_BITS) - 1);

  logic [CFG_DATA_W-1:0] screen_width;
  logic [CFG_DATA_W-1:0] screen_height;

  function automatic logic [COORD_BITS-1:0] bound_of(input logic [CFG_DATA_W-1:0] scr);
    logic [BW-1:0] b;
    b = BW'(scr) - BW'(1);
    if (scr == '0) begin
      b = '0;
    end
    if (b > CMAX) begin
      b = CMAX;
    end
    return b[COORD_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      wheel_mode    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_WHEEL_MODE:    wheel_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign bound_x = bound_of(screen_width);
  assign bound_y = bound_of(screen_height);

endmodule

`default_nettype wire

// ===== design/ps2m_core.sv =====
// packet assembly, cursor and wheel state, per-item result logic
`default_nettype none

module ps2m_core import ps2m_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int WHEEL_BITS = WHEEL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire in_item_t              item,
  input  wire logic [COORD_BITS-1:0] bound_x,
  input  wire logic [COORD_BITS-1:0] bound_y,
  input  wire logic                  wheel_mode,
  output out_item_t                  result
);

  localparam int CMAX = (1 << COORD_BITS) - 1;
  localparam int HALF_W = int'(WIDTH_RESET) / 2;
  localparam int HALF_H = int'(HEIGHT_RESET) / 2;
  localparam logic [COORD_BITS-1:0] POS_X_RST = COORD_BITS'((HALF_W > CMAX) ? CMAX : HALF_W);
  localparam logic [COORD_BITS-1:0] POS_Y_RST = COORD_BITS'((HALF_H > CMAX) ? CMAX : HALF_H);
  localparam int SW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam int WW = WHEEL_BITS + 1;

  logic [1:0]                   byte_phase;
  logic [7:0]                   packet_bytes [3];
  logic [COORD_BITS-1:0]        pos_x;
  logic [COORD_BITS-1:0]        pos_y;
  logic [2:0]                   button_state;
  logic                         event_flag;
  logic signed [WHEEL_BITS-1:0] wheel_sum;

  logic [1:0]                   byte_phase_next;
  logic [COORD_BITS-1:0]        pos_x_next;
  logic [COORD_BITS-1:0]        pos_y_next;
  logic [2:0]                   button_state_next;
  logic                         event_flag_next;
  logic signed [WHEEL_BITS-1:0] wheel_sum_next;

  logic [COORD_BITS-1:0]        px0, py0, cx, cy;
  logic [7:0]                   b0, b1, b2;
  logic                         is_byte, inject, poll, complete, apply_pkt, apply_wheel, moved;
  logic signed [16:0]           dx_sel, dy_sel;
  logic signed [WW-1:0]         wsum, zsel;
  logic signed [WHEEL_BITS-1:0] wsat, wh_out;
  logic [2:0]                   status;

  function automatic logic [COORD_BITS-1:0] move_clamp(input logic [COORD_BITS-1:0] p,
                                                      input logic signed [16:0] d,
                                                      input logic [COORD_BITS-1:0] hi);
    logic signed [SW-1:0] s;
    logic [COORD_BITS-1:0] r;
    s = $signed({{(SW-COORD_BITS){1'b0}}, p}) + SW'(d);
    if (s[SW-1]) begin
      r = '0;
    end else if (s > $signed({{(SW-COORD_BITS){1'b0}}, hi})) begin
      r = hi;
    end else begin
      r = s[COORD_BITS-1:0];
    end
    return r;
  endfunction

  always_comb begin
    px0 = (pos_x > bound_x) ? bound_x : pos_x;
    py0 = (pos_y > bound_y) ? bound_y : pos_y;

    is_byte = (item.func == FUNC_BYTE) && item.from_mouse;
    inject  = (item.func == FUNC_INJECT);
    poll    = (item.func == FUNC_POLL);

    b0 = packet_bytes[0];
    b1 = packet_bytes[1];
    b2 = (byte_phase == 2'd2) ? item.data_byte : packet_bytes[2];

    complete  = is_byte && (((byte_phase == 2'd2) && !wheel_mode) || (byte_phase == 2'd3));
    apply_pkt = complete && !(|b0[7:6]);
    moved     = inject || apply_pkt;

    // packet deltas are 9-bit signed, y axis inverted
    if (inject) begin
      dx_sel = 17'(item.delta_x);
      dy_sel = 17'(item.delta_y);
    end else begin
      dx_sel = 17'($signed({b0[4], b1}));
      dy_sel = -17'($signed({b0[5], b2}));
    end
    cx = move_clamp(px0, dx_sel, bound_x);
    cy = move_clamp(py0, dy_sel, bound_y);

    apply_wheel = inject || (apply_pkt && wheel_mode);
    zsel = inject ? WW'(item.wheel_delta) : WW'($signed(item.data_byte[3:0]));
    wsum = WW'(wheel_sum) + zsel;
    if (wsum[WW-1] != wsum[WW-2]) begin
      wsat = wsum[WW-1] ? {1'b1, {(WHEEL_BITS-1){1'b0}}} : {1'b0, {(WHEEL_BITS-1){1'b1}}};
    end else begin
      wsat = wsum[WHEEL_BITS-1:0];
    end

    pos_x_next        = moved ? cx : px0;
    pos_y_next        = moved ? cy : py0;
    button_state_next = inject ? item.button_bits[2:0] : (apply_pkt ? b0[2:0] : button_state);
    event_flag_next   = moved ? 1'b1 : event_flag;
    wh_out            = apply_wheel ? wsat : wheel_sum;
    wheel_sum_next    = wh_out;

    byte_phase_next = byte_phase;
    status          = ST_IGNORED;
    if (is_byte) begin
      case (byte_phase)
        2'd0: begin
          if (item.data_byte[3]) begin
            byte_phase_next = 2'd1;
            status          = ST_STORED;
          end else begin
            status = ST_RESYNC;
          end
        end
        2'd1: begin
          byte_phase_next = 2'd2;
          status          = ST_STORED;
        end
        2'd2: begin
          if (wheel_mode) begin
            byte_phase_next = 2'd3;
            status          = ST_STORED;
          end else begin
            byte_phase_next = 2'd0;
            status          = apply_pkt ? ST_APPLIED : ST_OVF;
          end
        end
        default: begin
          byte_phase_next = 2'd0;
          status          = apply_pkt ? ST_APPLIED : ST_OVF;
        end
      endcase
    end else if (inject || poll) begin
      status = ST_OTHER;
    end

    result.cursor_x    = 12'(pos_x_next);
    result.cursor_y    = 12'(pos_y_next);
    result.buttons     = button_state_next;
    result.event_seen  = event_flag_next;
    result.wheel_total = 16'(wh_out);
    result.item_status = status;

    // poll reports, then clears
    if (poll) begin
      event_flag_next = 1'b0;
      wheel_sum_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= 2'd0;
      pos_x        <= POS_X_RST;
      pos_y        <= POS_Y_RST;
      button_state <= 3'd0;
      event_flag   <= 1'b0;
      wheel_sum    <= '0;
    end else if (step) begin
      byte_phase   <= byte_phase_next;
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      button_state <= button_state_next;
      event_flag   <= event_flag_next;
      wheel_sum    <= wheel_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_byte) begin
      case (byte_phase)
        2'd0: begin
          if (item.data_byte[3]) begin
            packet_bytes[0] <= item.data_byte;
          end
        end
        2'd1: packet_bytes[1] <= item.data_byte;
        2'd2: packet_bytes[2] <= item.data_byte;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2_mouse_packet_cursor_tracker.sv =====
// top level of the ps/2 mouse packet decoder with cursor tracking
//
//   port group   dir   handshake              content
//   cfg_*        in    cfg_wr_en              register index and write data
//   in_*         in    in_valid / in_ready    in_item_t
//   out_*        out   out_valid / out_ready  out_item_t
//
// one item per cycle sustained while out_ready stays high; an item passes the input register, then the result register
// each item's update is one pass of add, clamp and saturate logic in the core
// reset clears packet phase, buttons, event flag and wheel sum, centers the cursor
// a stalled output holds its item while the input register still takes one more
`default_nettype none

module ps2_mouse_packet_cursor_tracker import ps2m_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int WHEEL_BITS = WHEEL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item
);

  logic                  s1_valid;
  in_item_t              s1_item;
  logic                  adv;
  logic [COORD_BITS-1:0] bound_x;
  logic [COORD_BITS-1:0] bound_y;
  logic                  wheel_mode;
  out_item_t             result;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  ps2m_cfg #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bound_x   (bound_x),
    .bound_y   (bound_y),
    .wheel_mode(wheel_mode)
  );

  ps2m_core #(
    .COORD_BITS(COORD_BITS),
    .WHEEL_BITS(WHEEL_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .item      (s1_item),
    .bound_x   (bound_x),
    .bound_y   (bound_y),
    .wheel_mode(wheel_mode),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (adv) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire
